// ----- sv/tcgr_pkg.sv -----
`timescale 1ns / 1ps

package tcgr_pkg;

  // defaults for the top level parameters
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int COORD_BITS_DEF  = 12;

  // fixed font geometry
  localparam int GLYPH_ROWS = 16;
  localparam int ROW_W      = 4;

  // field widths
  localparam int OP_W      = 2;
  localparam int CODE_W    = 8;
  localparam int FADDR_W   = 12;
  localparam int FBYTE_W   = 8;
  localparam int POS_W     = 12;
  localparam int MASK_W    = 8;
  localparam int COLOUR_W  = 32;
  localparam int SCREEN_W  = 12;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // cursor steps
  localparam int CHAR_STEP   = 8;
  localparam int LINE_STEP   = 16;
  localparam int SCROLL_LINE = 17;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // reset values of the registers
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [COLOUR_W-1:0] DRAW_COLOUR_RST   = 32'h00FF_FFFF;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DRAW_COLOUR   = 2'd2;

  // input operations
  localparam logic [OP_W-1:0] OP_FONT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CHAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;

  // result kinds
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_SET,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_SCROLL
  } cursor_cmd_t;

  typedef struct packed {
    logic        font_wr;
    logic        char_start;
    logic        row_load;
    logic        scroll_load;
    logic        row_tlast;
    cursor_cmd_t cursor_cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic can_load;
    logic row_last;
    logic line_wrap;
    logic line_scroll;
  } dp_status_t;

endpackage

// ----- sv/text_console_glyph_renderer_unit.sv -----
`timescale 1ns / 1ps

// Text console renderer for an 8x16 bitmap font. Font-write beats (op 0) fill the glyph
// store one row at a time, and set-cursor beats (op 2) move the pixel cursor; both leave
// the block idle. A character beat (op 1) produces 16 glyph-row beats at the cursor, then
// advances the cursor and, when the line wraps past the bottom, adds a scroll beat; it
// keeps the input closed until its last beat is loaded, since the glyph store has a single
// registered read port delivering one row per cycle while the output does not stall. A
// newline moves the cursor to the next line and adds a scroll beat when that scrolls. The
// last beat of each character or scrolling newline carries tlast. The glyph store has no
// reset: draw only glyphs that have been written.
module text_console_glyph_renderer_unit
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // char_code[7:0], font_addr[19:8], font_byte[27:20],
  // new_cursor_x[39:28], new_cursor_y[51:40], zero[55:52]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // row_x[11:0], row_y[23:12], pixel_mask[31:24], paint_value[63:32]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind[0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [SCREEN_W-1:0] screen_width_r;
  logic [SCREEN_W-1:0] screen_height_r;
  logic [COLOUR_W-1:0] draw_colour_r;
  logic                cfg_wr;
  logic [1:0]          cfg_reg;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [CODE_W-1:0]   in_char_code;
  logic [FADDR_W-1:0]  in_font_addr;
  logic [FBYTE_W-1:0]  in_font_byte;
  logic [POS_W-1:0]    in_new_cursor_x;
  logic [POS_W-1:0]    in_new_cursor_y;
  logic [POS_W-1:0]    out_row_x;
  logic [POS_W-1:0]    out_row_y;
  logic [MASK_W-1:0]   out_pixel_mask;
  logic [COLOUR_W-1:0] out_paint_value;

  assign in_char_code    = in_tdata[7:0];
  assign in_font_addr    = in_tdata[19:8];
  assign in_font_byte    = in_tdata[27:20];
  assign in_new_cursor_x = in_tdata[39:28];
  assign in_new_cursor_y = in_tdata[51:40];

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_reg    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      draw_colour_r   <= DRAW_COLOUR_RST;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_pwdata[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_pwdata[SCREEN_W-1:0];
        REG_DRAW_COLOUR:   draw_colour_r   <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_SCREEN_WIDTH:  cfg_prdata = CFG_DATA_W'(screen_width_r);
      REG_SCREEN_HEIGHT: cfg_prdata = CFG_DATA_W'(screen_height_r);
      REG_DRAW_COLOUR:   cfg_prdata = draw_colour_r;
      default:           cfg_prdata = '0;
    endcase
  end

  tcgr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_op        (in_tuser),
    .in_is_newline(in_char_code == NEWLINE_CODE),
    .in_tready    (in_tready),
    .status       (status),
    .cmd          (cmd)
  );

  tcgr_datapath #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_char_code   (in_char_code),
    .in_font_addr   (in_font_addr),
    .in_font_byte   (in_font_byte),
    .in_new_cursor_x(in_new_cursor_x),
    .in_new_cursor_y(in_new_cursor_y),
    .screen_width   (screen_width_r),
    .screen_height  (screen_height_r),
    .draw_colour    (draw_colour_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (out_tuser),
    .out_row_x      (out_row_x),
    .out_row_y      (out_row_y),
    .out_pixel_mask (out_pixel_mask),
    .out_paint_value(out_paint_value),
    .out_last       (out_tlast)
  );

  assign out_tdata = {out_paint_value, out_pixel_mask, out_row_y, out_row_x};

  // a glyph keeps the input side closed while its rows go out
  a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_CHAR) && (in_tdata[7:0] != NEWLINE_CODE)
    |=> !in_tready)
    else $error("input accepted right after a glyph started");

  a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SCROLL) |-> out_tlast)
    else $error("scroll beat without tlast");

  a_scroll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SCROLL) |-> (out_tdata == '0))
    else $error("scroll beat with nonzero data");

endmodule

// ----- sv/tcgr_ram.sv -----
`timescale 1ns / 1ps

module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/tcgr_ctrl.sv -----
`timescale 1ns / 1ps

module tcgr_ctrl
  import tcgr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [OP_W-1:0] in_op,
  input  logic            in_is_newline,
  output logic            in_tready,
  input  dp_status_t      status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ROWS   = 3'b010,
    ST_SCROLL = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd            = '0;
    cmd.cursor_cmd = CUR_HOLD;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_op)
            OP_FONT: begin
              cmd.font_wr = 1'b1;
            end
            OP_CURSOR: begin
              cmd.cursor_cmd = CUR_SET;
            end
            OP_CHAR: begin
              if (in_is_newline) begin
                cmd.cursor_cmd = CUR_NEWLINE;
                if (status.line_scroll) begin
                  state_nxt = ST_SCROLL;
                end
              end else begin
                cmd.char_start = 1'b1;
                state_nxt      = ST_ROWS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROWS: begin
        if (status.can_load) begin
          cmd.row_load = 1'b1;
          if (status.row_last) begin
            // cursor still holds its pre-character value here
            cmd.cursor_cmd = CUR_ADVANCE;
            cmd.row_tlast  = !(status.line_wrap && status.line_scroll);
            state_nxt      = (status.line_wrap && status.line_scroll) ? ST_SCROLL : ST_IDLE;
          end
        end
      end
      ST_SCROLL: begin
        if (status.can_load) begin
          cmd.scroll_load = 1'b1;
          cmd.cursor_cmd  = CUR_SCROLL;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/tcgr_datapath.sv -----
`timescale 1ns / 1ps

module tcgr_datapath
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [CODE_W-1:0]   in_char_code,
  input  logic [FADDR_W-1:0]  in_font_addr,
  input  logic [FBYTE_W-1:0]  in_font_byte,
  input  logic [POS_W-1:0]    in_new_cursor_x,
  input  logic [POS_W-1:0]    in_new_cursor_y,
  input  logic [SCREEN_W-1:0] screen_width,
  input  logic [SCREEN_W-1:0] screen_height,
  input  logic [COLOUR_W-1:0] draw_colour,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [POS_W-1:0]    out_row_x,
  output logic [POS_W-1:0]    out_row_y,
  output logic [MASK_W-1:0]   out_pixel_mask,
  output logic [COLOUR_W-1:0] out_paint_value,
  output logic                out_last
);

  localparam int DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(GLYPH_COUNT);
  localparam int CMP_W  = ((COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W) + 1;

  logic [COORD_BITS-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_BITS-1:0] cursor_y_r, cursor_y_nxt;
  logic [IDX_W-1:0]      code_r;
  logic                  glyph_ok_r;
  logic [ROW_W-1:0]      row_r;

  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [POS_W-1:0]      out_row_x_r;
  logic [POS_W-1:0]      out_row_y_r;
  logic [MASK_W-1:0]     out_pixel_mask_r;
  logic [COLOUR_W-1:0]   out_paint_value_r;
  logic                  out_last_r;

  logic [COORD_BITS-1:0] x_step, y_line, y_row;
  logic                  can_load;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [FBYTE_W-1:0]    ram_rdata;
  logic [IDX_W-1:0]      in_idx;
  logic [ROW_W-1:0]      row_next;

  assign x_step = cursor_x_r + COORD_BITS'(CHAR_STEP);
  assign y_line = cursor_y_r + COORD_BITS'(LINE_STEP);
  assign y_row  = cursor_y_r + COORD_BITS'(row_r);

  assign can_load = !out_valid_r || out_ready;

  // size compares run one bit wider so the cursor sums do not wrap
  assign status.can_load    = can_load;
  assign status.row_last    = (row_r == ROW_W'(GLYPH_ROWS - 1));
  assign status.line_wrap   = (CMP_W'(x_step) + CMP_W'(CHAR_STEP)) > CMP_W'(screen_width);
  assign status.line_scroll = (CMP_W'(y_line) + CMP_W'(SCROLL_LINE)) >= CMP_W'(screen_height);

  // glyph store
  assign in_idx    = IDX_W'(in_char_code);
  assign row_next  = row_r + ROW_W'(1);
  assign ram_we    = cmd.font_wr && (32'(in_font_addr) < 32'(DEPTH));
  assign ram_waddr = ADDR_W'(in_font_addr);
  assign ram_re    = cmd.char_start || (cmd.row_load && !status.row_last);
  assign ram_raddr = cmd.char_start ? (ADDR_W'(in_idx) << ROW_W)
                                    : ((ADDR_W'(code_r) << ROW_W) | ADDR_W'(row_next));

  tcgr_ram #(
    .WIDTH(FBYTE_W),
    .DEPTH(DEPTH)
  ) u_glyph_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_font_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    case (cmd.cursor_cmd)
      CUR_SET: begin
        cursor_x_nxt = COORD_BITS'(in_new_cursor_x);
        cursor_y_nxt = COORD_BITS'(in_new_cursor_y);
      end
      CUR_NEWLINE: begin
        cursor_x_nxt = '0;
        cursor_y_nxt = y_line;
      end
      CUR_ADVANCE: begin
        if (status.line_wrap) begin
          cursor_x_nxt = '0;
          cursor_y_nxt = y_line;
        end else begin
          cursor_x_nxt = x_step;
        end
      end
      CUR_SCROLL: begin
        cursor_x_nxt = '0;
        cursor_y_nxt = cursor_y_r - COORD_BITS'(SCROLL_LINE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      if (cmd.char_start) begin
        row_r <= '0;
      end else if (cmd.row_load) begin
        row_r <= row_next;
      end
      if (cmd.row_load || cmd.scroll_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.char_start) begin
      code_r     <= in_idx;
      glyph_ok_r <= 32'(in_char_code) < 32'(GLYPH_COUNT);
    end
    if (cmd.row_load) begin
      out_kind_r        <= KIND_ROW;
      out_row_x_r       <= POS_W'(cursor_x_r);
      out_row_y_r       <= POS_W'(y_row);
      out_pixel_mask_r  <= glyph_ok_r ? ram_rdata : '0;
      out_paint_value_r <= draw_colour;
      out_last_r        <= cmd.row_tlast;
    end else if (cmd.scroll_load) begin
      out_kind_r        <= KIND_SCROLL;
      out_row_x_r       <= '0;
      out_row_y_r       <= '0;
      out_pixel_mask_r  <= '0;
      out_paint_value_r <= '0;
      out_last_r        <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_row_x       = out_row_x_r;
  assign out_row_y       = out_row_y_r;
  assign out_pixel_mask  = out_pixel_mask_r;
  assign out_paint_value = out_paint_value_r;
  assign out_last        = out_last_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb
  import tcgr_pkg::*;
();

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CODE_W-1:0]  code;
    logic [FADDR_W-1:0] faddr;
    logic [FBYTE_W-1:0] fbyte;
    logic [POS_W-1:0]   nx;
    logic [POS_W-1:0]   ny;
  } console_cmd_t;

  typedef struct packed {
    logic                kind;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [MASK_W-1:0]   mask;
    logic [COLOUR_W-1:0] value;
    logic                last;
  } paint_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  text_console_glyph_renderer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted block state
  logic [FBYTE_W-1:0]  font_mem [GLYPH_COUNT_DEF*GLYPH_ROWS];
  logic [POS_W-1:0]    cur_x = '0;
  logic [POS_W-1:0]    cur_y = '0;
  logic [SCREEN_W-1:0] scr_w;
  logic [SCREEN_W-1:0] scr_h;
  logic [COLOUR_W-1:0] colour;

  console_cmd_t cmd_q [$];
  paint_beat_t  paint_q [$];
  console_cmd_t drv_cmd;

  // which glyph rows the stimulus has written so far
  bit         row_set [GLYPH_COUNT_DEF*GLYPH_ROWS];
  bit         glyph_ok [GLYPH_COUNT_DEF];
  logic [7:0] ok_list [$];

  int sender_idle_pct;
  int stall_pct;
  int errors = 0;
  int cmds_sent = 0;
  int chars_drawn = 0;
  int beats_checked = 0;
  int scrolls_seen = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // moves the cursor to the next line, returns 1 when the screen scrolls
  function automatic bit next_line();
    cur_x = '0;
    cur_y = cur_y + POS_W'(LINE_STEP);
    if ({1'b0, cur_y} + 13'(SCROLL_LINE) >= {1'b0, scr_h}) begin
      cur_x = '0;
      cur_y = cur_y - POS_W'(SCROLL_LINE);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_cmd(input console_cmd_t c);
    paint_beat_t b;
    paint_beat_t sb;
    paint_beat_t fresh [$];
    int r;
    sb = '0;
    sb.kind = KIND_SCROLL;
    case (c.op)
      OP_FONT: begin
        font_mem[c.faddr] = c.fbyte;
      end
      OP_CURSOR: begin
        cur_x = c.nx;
        cur_y = c.ny;
      end
      OP_CHAR: begin
        if (c.code == NEWLINE_CODE) begin
          if (next_line()) fresh.push_back(sb);
        end else begin
          chars_drawn++;
          for (r = 0; r < GLYPH_ROWS; r++) begin
            b.kind  = KIND_ROW;
            b.x     = cur_x;
            b.y     = cur_y + POS_W'(r);
            b.mask  = font_mem[{c.code, 4'(r)}];
            b.value = colour;
            b.last  = 1'b0;
            fresh.push_back(b);
          end
          cur_x = cur_x + POS_W'(CHAR_STEP);
          if ({1'b0, cur_x} + 13'(CHAR_STEP) > {1'b0, scr_w}) begin
            if (next_line()) fresh.push_back(sb);
          end
        end
      end
      default: ;
    endcase
    if (fresh.size() != 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) paint_q.push_back(fresh[i]);
  endtask

  // input driver
  always @(posedge clk) begin : drive_cmds
    console_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_cmd(drv_cmd);
        cmds_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          c = cmd_q.pop_front();
          drv_cmd   <= c;
          in_tdata  <= {4'b0, c.ny, c.nx, c.fbyte, c.faddr, c.code};
          in_tuser  <= c.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_paint
    paint_beat_t got;
    paint_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        got.kind  = out_tuser;
        got.x     = out_tdata[11:0];
        got.y     = out_tdata[23:12];
        got.mask  = out_tdata[31:24];
        got.value = out_tdata[63:32];
        got.last  = out_tlast;
        beats_checked++;
        if (got.kind == KIND_SCROLL) scrolls_seen++;
        if (paint_q.size() == 0) begin
          $display("%0t: unexpected beat kind %0d x %0d y %0d mask %02h value %08h last %0d",
                   $time, got.kind, got.x, got.y, got.mask, got.value, got.last);
          errors++;
        end else begin
          want = paint_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected kind %0d x %0d y %0d mask %02h value %08h last %0d",
                     $time, want.kind, want.x, want.y, want.mask, want.value, want.last);
            $display("%0t:           actual kind %0d x %0d y %0d mask %02h value %08h last %0d",
                     $time, got.kind, got.x, got.y, got.mask, got.value, got.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = data[SCREEN_W-1:0];
      REG_SCREEN_HEIGHT: scr_h = data[SCREEN_W-1:0];
      REG_DRAW_COLOUR:   colour = data;
      default: ;
    endcase
  endtask

  // fields that the operation ignores carry random values
  function automatic console_cmd_t noise_cmd(input logic [OP_W-1:0] op);
    console_cmd_t c;
    c.op    = op;
    c.code  = $urandom;
    c.faddr = $urandom;
    c.fbyte = $urandom;
    c.nx    = $urandom;
    c.ny    = $urandom;
    return c;
  endfunction

  task automatic push_font(input logic [FADDR_W-1:0] addr, input logic [FBYTE_W-1:0] data);
    console_cmd_t c;
    bit full;
    int r;
    c = noise_cmd(OP_FONT);
    c.faddr = addr;
    c.fbyte = data;
    cmd_q.push_back(c);
    row_set[addr] = 1'b1;
    if (!glyph_ok[addr[11:4]]) begin
      full = 1'b1;
      for (r = 0; r < GLYPH_ROWS; r++) begin
        if (!row_set[{addr[11:4], 4'(r)}]) full = 1'b0;
      end
      if (full) begin
        glyph_ok[addr[11:4]] = 1'b1;
        ok_list.push_back(addr[11:4]);
      end
    end
  endtask

  task automatic push_char(input logic [CODE_W-1:0] code);
    console_cmd_t c;
    c = noise_cmd(OP_CHAR);
    c.code = code;
    cmd_q.push_back(c);
  endtask

  task automatic push_cursor(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    console_cmd_t c;
    c = noise_cmd(OP_CURSOR);
    c.nx = x;
    c.ny = y;
    cmd_q.push_back(c);
  endtask

  task automatic define_glyph(input logic [7:0] g);
    int r;
    for (r = 0; r < GLYPH_ROWS; r++) begin
      push_font({g, 4'(r)}, (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom));
    end
  endtask

  task automatic random_burst(input int budget);
    int n;
    int sel;
    n = 0;
    while (n < budget) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        define_glyph($urandom);
        n += GLYPH_ROWS;
      end else if (sel < 62) begin
        push_char(ok_list[$urandom_range(ok_list.size()-1)]);
        n++;
      end else if (sel < 72) begin
        push_char(NEWLINE_CODE);
        n++;
      end else if (sel < 78) begin
        push_cursor($urandom, $urandom);
        n++;
      end else if (sel < 86) begin
        // close to the right and bottom edges, so wraps and scrolls come often
        push_cursor(scr_w - POS_W'(CHAR_STEP * $urandom_range(1, 4)),
                    scr_h - POS_W'($urandom_range(SCROLL_LINE, 60)));
        n++;
      end else if (sel < 94) begin
        push_font($urandom, $urandom);
        n++;
      end else begin
        cmd_q.push_back(noise_cmd(2'd3));
        n++;
      end
    end
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || in_tvalid || paint_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    scr_w       = SCREEN_WIDTH_RST;
    scr_h       = SCREEN_HEIGHT_RST;
    colour      = DRAW_COLOUR_RST;
    sender_idle_pct = 0;
    stall_pct       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset settings
    define_glyph(8'hFF);
    push_char(8'hFF);
    push_cursor(12'd632, 12'd0);     // end of line wraps
    push_char(8'hFF);
    push_cursor(12'd0, 12'd463);     // newline that scrolls
    push_char(NEWLINE_CODE);
    push_cursor(12'd0, 12'd0);       // newline without scroll
    push_char(NEWLINE_CODE);
    push_cursor(12'd632, 12'd447);   // wrap followed by scroll
    push_char(8'hFF);
    push_cursor(12'hFFF, 12'hFFF);   // coordinates wrap around
    push_char(8'hFF);
    cmd_q.push_back(noise_cmd(2'd3));
    push_font(12'hFFF, 8'h5A);
    drain();

    // narrowest and shortest screen: every character wraps and scrolls
    write_reg(REG_SCREEN_WIDTH, 32'd8);
    write_reg(REG_SCREEN_HEIGHT, 32'd17);
    write_reg(REG_DRAW_COLOUR, 32'h0000_0000);
    define_glyph(8'h00);
    push_char(8'h00);
    random_burst(26);
    drain();

    write_reg(REG_SCREEN_WIDTH, 32'd4095);
    write_reg(REG_SCREEN_HEIGHT, 32'd4095);
    write_reg(REG_DRAW_COLOUR, 32'hFFFF_FFFF);
    sender_idle_pct = 69;
    random_burst(28);
    drain();

    write_reg(REG_SCREEN_WIDTH, 32'd640);
    write_reg(REG_SCREEN_HEIGHT, 32'd480);
    write_reg(REG_DRAW_COLOUR, $urandom);
    sender_idle_pct = 0;
    stall_pct       = 69;
    random_burst(28);
    drain();

    write_reg(REG_SCREEN_WIDTH, $urandom_range(8, 200));
    write_reg(REG_SCREEN_HEIGHT, $urandom_range(17, 200));
    write_reg(REG_DRAW_COLOUR, $urandom);
    sender_idle_pct = 20;
    stall_pct       = 20;
    random_burst(28);
    drain();

    $display("%0d commands sent over 5 screen settings, %0d characters drawn", cmds_sent,
             chars_drawn);
    $display("%0d result beats checked, %0d of them scrolls, %0d errors", beats_checked,
             scrolls_seen, errors);
    if (errors == 0) begin
      $display("text_console_glyph_renderer_unit test passed");
    end else begin
      $display("text_console_glyph_renderer_unit test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout waiting for results");
    $display("text_console_glyph_renderer_unit test failed");
    $finish;
  end

endmodule
